/* rtl/core/rti_pkg.sv */
package rti_pkg;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;

  typedef struct packed {
    logic vld;
    logic hit;
    logic negt;
  } rti_ctl_t;

endpackage

/* rtl/core/rti_front.sv */
module rti_front #(
  parameter int CW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] corner [3],
  input  logic signed [CW-1:0] side_a [3],
  input  logic signed [CW-1:0] side_b [3],
  input  logic signed [CW-1:0] org    [3],
  input  logic signed [CW-1:0] dir    [3],
  output logic                 out_vld,
  output logic signed [2*CW+1:0] pv [3],
  output logic signed [2*CW+1:0] qv [3],
  output logic signed [CW-1:0] e1 [3],
  output logic signed [CW-1:0] e2 [3],
  output logic signed [CW:0]   tv [3]
);

  logic                 vld1_r, vld2_r, vld3_r;
  logic signed [CW:0]   tv1_r [3];
  logic signed [CW-1:0] e1_1_r [3];
  logic signed [CW-1:0] e2_1_r [3];
  logic signed [CW:0]   tv2_r [3];
  logic signed [CW-1:0] e1_2_r [3];
  logic signed [CW-1:0] e2_2_r [3];
  logic signed [CW:0]   tv3_r [3];
  logic signed [CW-1:0] e1_3_r [3];
  logic signed [CW-1:0] e2_3_r [3];
  logic signed [2*CW-1:0] pp_r [3];
  logic signed [2*CW-1:0] pn_r [3];
  logic signed [2*CW:0]   qp_r [3];
  logic signed [2*CW:0]   qn_r [3];
  logic signed [2*CW+1:0] pv_r [3];
  logic signed [2*CW+1:0] qv_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    always_ff @(posedge clk) begin
      tv1_r[i]  <= org[i] - corner[i];
      e1_1_r[i] <= side_a[i];
      e2_1_r[i] <= side_b[i];

      pp_r[i]   <= dir[J] * e2_1_r[K];
      pn_r[i]   <= dir[K] * e2_1_r[J];
      qp_r[i]   <= tv1_r[J] * e1_1_r[K];
      qn_r[i]   <= tv1_r[K] * e1_1_r[J];
      tv2_r[i]  <= tv1_r[i];
      e1_2_r[i] <= e1_1_r[i];
      e2_2_r[i] <= e2_1_r[i];

      pv_r[i]   <= pp_r[i] - pn_r[i];
      qv_r[i]   <= qp_r[i] - qn_r[i];
      tv3_r[i]  <= tv2_r[i];
      e1_3_r[i] <= e1_2_r[i];
      e2_3_r[i] <= e2_2_r[i];
    end

    assign pv[i] = pv_r[i];
    assign qv[i] = qv_r[i];
    assign e1[i] = e1_3_r[i];
    assign e2[i] = e2_3_r[i];
    assign tv[i] = tv3_r[i];
  end

  assign out_vld = vld3_r;

endmodule

/* rtl/core/rti_dots.sv */
module rti_dots #(
  parameter int CW   = 24,
  parameter int FRAC = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic signed [2*CW+1:0] pv [3],
  input  logic signed [2*CW+1:0] qv [3],
  input  logic signed [CW-1:0]   e1 [3],
  input  logic signed [CW-1:0]   e2 [3],
  input  logic signed [CW:0]     tv [3],
  input  logic signed [CW-1:0]   dir [3],
  output rti_pkg::rti_ctl_t      ctl,
  output logic [3*CW+5+FRAC-1:0] mag,
  output logic [3*CW+4:0]        den
);

  localparam int VW  = 2 * CW + 2;
  localparam int L   = VW / 2;
  localparam int PHW = CW + 1 + (VW - L);
  localparam int PLW = CW + 2 + L;
  localparam int DW  = 3 * CW + 5;
  localparam int MW  = DW + FRAC;

  logic signed [CW:0]    opa [4][3];
  logic signed [VW-1:0]  opb [4][3];
  logic signed [PHW-1:0] ph_r [4][3];
  logic signed [PLW-1:0] pl_r [4][3];
  logic signed [DW-1:0]  s_nxt [4];
  logic signed [DW-1:0]  s_r [4];
  logic                  va_r, vb_r;
  rti_pkg::rti_ctl_t     ctl_r;
  logic [MW-1:0]         mag_r;
  logic [DW-1:0]         den_r;
  logic signed [DW:0]    du, duv;
  logic                  det_pos, hit;
  logic [DW-1:0]         tabs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[0][i] = e1[i];
      opa[1][i] = tv[i];
      opa[2][i] = dir[i];
      opa[3][i] = e2[i];
      opb[0][i] = pv[i];
      opb[1][i] = pv[i];
      opb[2][i] = qv[i];
      opb[3][i] = qv[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 3; i++) begin
        ph_r[d][i] <= opa[d][i] * $signed(opb[d][i][VW-1:L]);
        pl_r[d][i] <= opa[d][i] * $signed({1'b0, opb[d][i][L-1:0]});
      end
    end
  end

  always_comb begin
    for (int d = 0; d < 4; d++) begin
      s_nxt[d] = '0;
      for (int i = 0; i < 3; i++) begin
        s_nxt[d] = s_nxt[d] + (DW'(ph_r[d][i]) <<< L) + DW'(pl_r[d][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 4; d++) begin
      s_r[d] <= s_nxt[d];
    end
  end

  // s_r: det, u, v, t
  always_comb begin
    det_pos = !s_r[0][DW-1] && (|s_r[0]);
    du      = (DW+1)'(s_r[0]) - (DW+1)'(s_r[1]);
    duv     = du - (DW+1)'(s_r[2]);
    hit     = vb_r && det_pos && !s_r[1][DW-1] && !du[DW] && !s_r[2][DW-1] && !duv[DW];
    tabs    = s_r[3][DW-1] ? DW'(-s_r[3]) : DW'(s_r[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      ctl_r <= '0;
    end else begin
      va_r       <= in_vld;
      vb_r       <= va_r;
      ctl_r.vld  <= vb_r;
      ctl_r.hit  <= hit;
      ctl_r.negt <= s_r[3][DW-1];
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= MW'(tabs) << FRAC;
    den_r <= s_r[0];
  end

  assign ctl = ctl_r;
  assign mag = mag_r;
  assign den = den_r;

endmodule

/* rtl/core/rti_div.sv */
module rti_div #(
  parameter int CW   = 24,
  parameter int FRAC = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rti_pkg::rti_ctl_t      ctl,
  input  logic [3*CW+5+FRAC-1:0] mag,
  input  logic [3*CW+4:0]        den,
  output logic                   out_vld,
  output logic                   out_hit,
  output logic signed [CW-1:0]   out_dist,
  output logic                   out_clip
);

  localparam int DW = 3 * CW + 5;
  localparam int RW = DW + CW + FRAC;
  localparam logic [CW-1:0] MAXP = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINN = {1'b1, {(CW-1){1'b0}}};

  rti_pkg::rti_ctl_t ctl_r [CW+1];
  logic [RW-1:0]     r_r   [CW+1];
  logic [CW:0]       q_r   [CW+1];
  logic [DW-1:0]     den_r [CW+1];

  // restoring divide, one quotient bit per stage, MSB first
  for (genvar k = 0; k <= CW; k++) begin : g_stage
    localparam int S = CW - k;
    rti_pkg::rti_ctl_t cin;
    logic [RW-1:0]     rin, bsh;
    logic [CW:0]       qin;
    logic [DW-1:0]     din;
    logic              ge;

    if (k == 0) begin : g_first
      assign cin = ctl;
      assign rin = RW'(mag);
      assign qin = '0;
      assign din = den;
    end else begin : g_next
      assign cin = ctl_r[k-1];
      assign rin = r_r[k-1];
      assign qin = q_r[k-1];
      assign din = den_r[k-1];
    end

    assign bsh = RW'(din) << S;
    assign ge  = rin >= bsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= cin;
      end
    end

    always_ff @(posedge clk) begin
      r_r[k]   <= ge ? rin - bsh : rin;
      q_r[k]   <= qin | ((CW+1)'(ge) << S);
      den_r[k] <= din;
    end
  end

  rti_pkg::rti_ctl_t cf;
  logic [CW:0]       qf;
  logic              pos_big, neg_big;
  logic              vld_r, hit_r, clip_r;
  logic [CW-1:0]     dist_r, dist_nxt;
  logic              clip_nxt;

  assign cf      = ctl_r[CW];
  assign qf      = q_r[CW];
  assign pos_big = qf[CW] | qf[CW-1];
  assign neg_big = qf[CW] | (qf[CW-1] & (|qf[CW-2:0]));

  always_comb begin
    dist_nxt = '0;
    clip_nxt = 1'b0;
    if (cf.hit) begin
      if (cf.negt) begin
        clip_nxt = neg_big;
        dist_nxt = neg_big ? MINN : -qf[CW-1:0];
      end else begin
        clip_nxt = pos_big;
        dist_nxt = pos_big ? MAXP : qf[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cf.vld;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= cf.hit;
    clip_r <= clip_nxt;
    dist_r <= dist_nxt;
  end

  assign out_vld  = vld_r;
  assign out_hit  = hit_r;
  assign out_clip = clip_r;
  assign out_dist = dist_r;

endmodule

/* rtl/core/ray_triangle_intersect_culling.sv */
// Throughput: one triangle per cycle; busy is always low.
// The divide resolves one quotient bit per stage over COORD_WIDTH + 1 stages.
// Reset (sync, active low) clears pipeline valids; origin = 0, dir = (0, 0, 1.0).
// Results cannot be stalled by the receiver.
module ray_triangle_intersect_culling #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_corner_x,
  input  logic signed [COORD_WIDTH-1:0] in_corner_y,
  input  logic signed [COORD_WIDTH-1:0] in_corner_z,
  input  logic signed [COORD_WIDTH-1:0] in_side_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_side_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_side_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_side_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_side_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_side_b_z,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [COORD_WIDTH-1:0] out_distance,
  output logic                          out_distance_clipped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = 3 * CW + 5;
  localparam int LAT = CW + 8;

  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] dir_r [3];
  logic signed [CW-1:0] corner [3];
  logic signed [CW-1:0] side_a [3];
  logic signed [CW-1:0] side_b [3];
  logic                 acc;

  logic                   f_vld;
  logic signed [2*CW+1:0] pv [3];
  logic signed [2*CW+1:0] qv [3];
  logic signed [CW-1:0]   e1 [3];
  logic signed [CW-1:0]   e2 [3];
  logic signed [CW:0]     tv [3];
  rti_pkg::rti_ctl_t      d_ctl;
  logic [DW+FRAC_BITS-1:0] d_mag;
  logic [DW-1:0]          d_den;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start & ~busy;

  assign corner[0] = in_corner_x;
  assign corner[1] = in_corner_y;
  assign corner[2] = in_corner_z;
  assign side_a[0] = in_side_a_x;
  assign side_a[1] = in_side_a_y;
  assign side_a[2] = in_side_a_z;
  assign side_b[0] = in_side_b_x;
  assign side_b[1] = in_side_b_y;
  assign side_b[2] = in_side_b_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= CW'(1) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rti_pkg::REG_ORIGIN_X: org_r[0] <= cfg_data;
        rti_pkg::REG_ORIGIN_Y: org_r[1] <= cfg_data;
        rti_pkg::REG_ORIGIN_Z: org_r[2] <= cfg_data;
        rti_pkg::REG_DIR_X:    dir_r[0] <= cfg_data;
        rti_pkg::REG_DIR_Y:    dir_r[1] <= cfg_data;
        rti_pkg::REG_DIR_Z:    dir_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rti_front #(.CW(CW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (acc),
    .corner (corner),
    .side_a (side_a),
    .side_b (side_b),
    .org    (org_r),
    .dir    (dir_r),
    .out_vld(f_vld),
    .pv     (pv),
    .qv     (qv),
    .e1     (e1),
    .e2     (e2),
    .tv     (tv)
  );

  rti_dots #(.CW(CW), .FRAC(FRAC_BITS)) u_dots (
    .clk   (clk),
    .rst_n (rst_n),
    .in_vld(f_vld),
    .pv    (pv),
    .qv    (qv),
    .e1    (e1),
    .e2    (e2),
    .tv    (tv),
    .dir   (dir_r),
    .ctl   (d_ctl),
    .mag   (d_mag),
    .den   (d_den)
  );

  rti_div #(.CW(CW), .FRAC(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (d_ctl),
    .mag     (d_mag),
    .den     (d_den),
    .out_vld (out_valid),
    .out_hit (out_hit),
    .out_dist(out_distance),
    .out_clip(out_distance_clipped)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result word without matching start");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_distance == '0 && !out_distance_clipped))
    else $error("miss word carries distance");

  a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_distance_clipped) |->
      (out_distance[CW-2:0] == {(CW-1){out_distance[CW-1] ? 1'b0 : 1'b1}}))
    else $error("clipped distance not saturated");
`endif

endmodule
